[hdl/jts_pkg.sv]
// jts_pkg: shared types and constants for the ISO-2022-JP to Shift_JIS transcoder
// holds the queued work record, character mode codes and escape progress codes
// no dependencies
package jts_pkg;

   // character modes
   localparam logic [2:0] MODE_UNKNOWN = 3'd0;
   localparam logic [2:0] MODE_ASCII   = 3'd1;
   localparam logic [2:0] MODE_X0208   = 3'd2;
   localparam logic [2:0] MODE_X0212   = 3'd3;
   localparam logic [2:0] MODE_KANA    = 3'd4;

   // escape sequence progress
   localparam logic [3:0] ESC_NONE              = 4'd0;
   localparam logic [3:0] ESC_SEEN              = 4'd1;
   localparam logic [3:0] ESC_DOLLAR            = 4'd2;
   localparam logic [3:0] ESC_PAREN             = 4'd3;
   localparam logic [3:0] ESC_AMP               = 4'd4;
   localparam logic [3:0] ESC_DOLLAR_PAREN      = 4'd5;
   localparam logic [3:0] ESC_AMP_AT            = 4'd6;
   localparam logic [3:0] ESC_AMP_AT_ESC        = 4'd7;
   localparam logic [3:0] ESC_AMP_AT_ESC_DOLLAR = 4'd8;

   // byte codes
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_ESC    = 8'h1B;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_AMP    = 8'h26;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_AT     = 8'h40;
   localparam logic [7:0] CH_B      = 8'h42;
   localparam logic [7:0] CH_D      = 8'h44;
   localparam logic [7:0] CH_H      = 8'h48;
   localparam logic [7:0] CH_I      = 8'h49;
   localparam logic [7:0] CH_J      = 8'h4A;

   // work for the back end: up to two bytes, then optionally the terminator
   typedef struct packed {
      logic [1:0] nbytes;
      logic [7:0] byte_a;
      logic [7:0] byte_b;
      logic       term;
   } op_type;

   // number of output beats an op produces
   function automatic logic [1:0] op_beats(input op_type op);
      return op.nbytes + {1'b0, op.term};
   endfunction

endpackage

[hdl/jts_front.sv]
// jts_front: accepts input bytes, tracks mode and escape state, builds output ops
// depends on jts_pkg
module jts_front (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic [7:0]     req_in_byte,
   input  logic           req_in_last,
   input  logic           q_full,
   output logic           push,
   output jts_pkg::op_type push_op
);
   import jts_pkg::*;

   logic [2:0] mode_ff, mode_in;
   logic [3:0] esc_ff, esc_in;
   logic [6:0] lead_ff, lead_in;
   logic       pend_ff, pend_in;
   logic       accept;
   logic       safe;
   logic [7:0] c1, c2;
   op_type     op;

   assign accept = req_valid && !q_full;
   assign safe   = (req_in_byte inside {[CH_SPACE:8'h7E], CH_TAB, CH_LF, CH_CR});
   assign c1     = {1'b1, lead_ff};
   assign c2     = req_in_byte | 8'h80;

   // classify the byte and compute next state
   always_comb begin
      mode_in = mode_ff;
      esc_in  = esc_ff;
      lead_in = lead_ff;
      pend_in = pend_ff;
      op      = '0;
      if (req_in_byte != CH_NUL) begin
         if (esc_ff != ESC_NONE) begin
            // escape sequence: any mismatch leaves unknown mode
            esc_in  = ESC_NONE;
            mode_in = MODE_UNKNOWN;
            case (esc_ff)
               ESC_SEEN: begin
                  if (req_in_byte == CH_DOLLAR) begin
                     esc_in  = ESC_DOLLAR;
                     mode_in = mode_ff;
                  end else if (req_in_byte == CH_LPAREN) begin
                     esc_in  = ESC_PAREN;
                     mode_in = mode_ff;
                  end else if (req_in_byte == CH_AMP) begin
                     esc_in  = ESC_AMP;
                     mode_in = mode_ff;
                  end
               end
               ESC_DOLLAR: begin
                  if (req_in_byte inside {CH_AT, CH_B}) begin
                     mode_in = MODE_X0208;
                  end else if (req_in_byte == CH_LPAREN) begin
                     esc_in  = ESC_DOLLAR_PAREN;
                     mode_in = mode_ff;
                  end
               end
               ESC_PAREN: begin
                  if (req_in_byte inside {CH_J, CH_H, CH_B}) begin
                     mode_in = MODE_ASCII;
                  end else if (req_in_byte == CH_I) begin
                     mode_in = MODE_KANA;
                  end
               end
               ESC_AMP: begin
                  if (req_in_byte == CH_AT) begin
                     esc_in  = ESC_AMP_AT;
                     mode_in = mode_ff;
                  end
               end
               ESC_DOLLAR_PAREN: begin
                  if (req_in_byte == CH_D) begin
                     mode_in = MODE_X0212;
                  end
               end
               ESC_AMP_AT: begin
                  if (req_in_byte == CH_ESC) begin
                     esc_in  = ESC_AMP_AT_ESC;
                     mode_in = mode_ff;
                  end
               end
               ESC_AMP_AT_ESC: begin
                  if (req_in_byte == CH_DOLLAR) begin
                     esc_in  = ESC_AMP_AT_ESC_DOLLAR;
                     mode_in = mode_ff;
                  end
               end
               ESC_AMP_AT_ESC_DOLLAR: begin
                  if (req_in_byte == CH_B) begin
                     mode_in = MODE_X0208;
                  end
               end
               default: begin
               end
            endcase
         end else if (pend_ff) begin
            // trail byte of a two-byte character
            pend_in = 1'b0;
            lead_in = '0;
            if (req_in_byte inside {[8'h21:8'h7E]}) begin
               op.nbytes = 2'd2;
               if (mode_ff == MODE_X0212) begin
                  op.byte_a = CH_SPACE;
                  op.byte_b = CH_SPACE;
               end else if (c1[0]) begin
                  op.byte_a = {1'b0, c1[7:1]} + ((c1 < 8'hDF) ? 8'h31 : 8'h71);
                  op.byte_b = c2 - 8'h60 - ((c2 < 8'hE0) ? 8'd1 : 8'd0);
               end else begin
                  op.byte_a = {1'b0, c1[7:1]} + ((c1 < 8'hDF) ? 8'h30 : 8'h70);
                  op.byte_b = c2 - 8'd2;
               end
            end
         end else if (!req_in_byte[7]) begin
            if (req_in_byte == CH_ESC) begin
               esc_in = ESC_SEEN;
            end else begin
               case (mode_ff)
                  MODE_ASCII: begin
                     if (safe) begin
                        op.nbytes = 2'd1;
                        op.byte_a = req_in_byte;
                     end
                  end
                  MODE_X0208, MODE_X0212: begin
                     if (req_in_byte inside {[8'h21:8'h7E]}) begin
                        lead_in = req_in_byte[6:0];
                        pend_in = 1'b1;
                     end else if (safe) begin
                        op.nbytes = 2'd1;
                        op.byte_a = req_in_byte;
                     end
                  end
                  MODE_KANA: begin
                     if (req_in_byte inside {[8'h21:8'h6F]}) begin
                        op.nbytes = 2'd1;
                        op.byte_a = req_in_byte | 8'h80;
                     end else if (safe) begin
                        op.nbytes = 2'd1;
                        op.byte_a = req_in_byte;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
      end
      // end of string: terminator and return to ascii
      if (req_in_byte == CH_NUL || req_in_last) begin
         op.term = 1'b1;
         mode_in = MODE_ASCII;
         esc_in  = ESC_NONE;
         lead_in = '0;
         pend_in = 1'b0;
      end
   end

   assign push    = accept && ((op.nbytes != 2'd0) || op.term);
   assign push_op = op;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_ASCII;
         esc_ff  <= ESC_NONE;
         pend_ff <= 1'b0;
      end else if (accept) begin
         mode_ff <= mode_in;
         esc_ff  <= esc_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         lead_ff <= lead_in;
      end
   end

endmodule

[hdl/jts_queue.sv]
// jts_queue: small first-in first-out queue of ops between front and back
// depends on jts_pkg
module jts_queue #(
   parameter int DEPTH = 4
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  jts_pkg::op_type push_op,
   output logic            full,
   input  logic            pop,
   output jts_pkg::op_type head_op,
   output logic            head_valid
);
   import jts_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   op_type          entry_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]   count_ff;

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_op    = entry_ff[rd_ptr_ff];

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

[hdl/jts_back.sv]
// jts_back: splits each queued op into output beats and holds the output register
// depends on jts_pkg
module jts_back (
   input  logic            clock,
   input  logic            reset,
   input  logic            head_valid,
   input  jts_pkg::op_type head_op,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_out_last
);
   import jts_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       load;

   assign load = head_valid && (!valid_ff || !rsp_stall);
   assign pop  = load && (idx_ff == op_beats(head_op) - 2'd1);

   // pick the beat at the current index
   always_comb begin
      if (idx_ff < head_op.nbytes) begin
         byte_in = (idx_ff == 2'd0) ? head_op.byte_a : head_op.byte_b;
         last_in = 1'b0;
      end else begin
         byte_in = CH_NUL;
         last_in = 1'b1;
      end
      idx_in = pop ? 2'd0 : idx_ff + 2'd1;
   end

   // beat index and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else if (load) begin
         idx_ff   <= idx_in;
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= byte_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_out_last = last_ff;

endmodule

[hdl/jis_to_sjis_transcoder.sv]
// jis_to_sjis_transcoder: ISO-2022-JP byte stream in, Shift_JIS byte stream out
// depends on jts_pkg, jts_front, jts_queue, jts_back
//
// Usage:
//   req channel carries one ISO-2022-JP byte per beat (req_in_byte) with
//   req_in_last marking the final byte of a string. A zero byte also ends it.
//   rsp channel carries Shift_JIS bytes; each string closes with a zero byte
//   beat that has rsp_out_last set.
//   One input beat produces zero to three output beats. The front end takes
//   one input beat per cycle as long as the op queue (DEPTH entries) has room;
//   the back end sends one output beat per cycle while rsp_stall is low, so
//   sustained throughput is one input beat per cycle for one-byte results
//   and falls where an input beat yields two or three output beats.
//   An accepted input beat is written to the op queue and then loaded into
//   the output register, where rsp_valid rises.
//   When the receiver asserts rsp_stall the output register holds its beat,
//   the queue fills, and req_stall rises once all DEPTH entries are taken.
//   Reset returns to ASCII mode with no escape or lead byte pending, empties
//   the queue and clears the output valid flag.
module jis_to_sjis_transcoder #(
   parameter int DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last
);
   import jts_pkg::*;

   logic   push, full, pop, head_valid;
   op_type push_op, head_op;

   assign req_stall = full;

   // classify input bytes
   jts_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .q_full      (full),
      .push        (push),
      .push_op     (push_op)
   );

   // decouple front and back
   jts_queue #(.DEPTH(DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_op    (push_op),
      .full       (full),
      .pop        (pop),
      .head_op    (head_op),
      .head_valid (head_valid)
   );

   // emit output beats
   jts_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head_op      (head_op),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

endmodule

[hdl/jts_checker.sv]
// jts_checker: port-level checks for the transcoder, bound to the top level
// depends on jis_to_sjis_transcoder
module jts_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_out_last
);

   // reset leaves output empty and input open
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("output valid or input stall after reset");

   // a stalled output beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_out_byte)
                                    && $stable(rsp_out_last)))
      else $error("stalled output beat changed");

   // only the terminator carries a zero byte
   a_term_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_out_byte == 8'h00) == rsp_out_last))
      else $error("terminator flag and zero byte disagree");

   // input never stalls in the first cycle after reset
   a_stall_needs_data: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_stall) |-> $past(!reset))
      else $error("input stalled right after reset");

endmodule

bind jis_to_sjis_transcoder jts_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_out_byte (rsp_out_byte),
   .rsp_out_last (rsp_out_last)
);
